### hdl/ffpa_pkg.sv
`timescale 1ns / 1ps

package ffpa_pkg;

  localparam int BYTES_W   = 24;
  localparam int INDEX_W   = 8;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 2;
  localparam int SUM_W     = BYTES_W + 2;

  localparam logic [BYTES_W-1:0] POOL_BYTES_RST = 24'd65536;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_EXHAUSTED = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_NO_FIT    = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_BAD_INDEX = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_POOL0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL1 = 2'd1;

  typedef struct packed {
    logic               action;
    logic               pool_select;
    logic [BYTES_W-1:0] request_bytes;
    logic [INDEX_W-1:0] free_index;
  } ffpa_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  block_index;
    logic [BYTES_W-1:0]  block_offset;
    logic [BYTES_W-1:0]  block_bytes;
  } ffpa_out_t;

  typedef struct packed {
    logic                 en;
    logic [CFG_IDX_W-1:0] idx;
    logic [BYTES_W-1:0]   value;
  } cfg_wr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FREE_RD,
    ST_WALK,
    ST_STUB,
    ST_DONE
  } state_t;

endpackage

### hdl/ffpa_core.sv
`timescale 1ns / 1ps

module ffpa_core
  import ffpa_pkg::*;
#(
  parameter int MAX_BLOCKS   = 256,
  parameter int HEADER_BYTES = 16,
  parameter int NUM_POOLS    = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      req_valid,
  output logic      req_ready,
  input  ffpa_in_t  req,
  input  cfg_wr_t   cfg,
  output logic      res_valid,
  input  logic      res_take,
  output ffpa_out_t res
);

  localparam int IW    = $clog2(MAX_BLOCKS);
  localparam int CW    = $clog2(MAX_BLOCKS + 1);
  localparam int PW    = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int DEPTH = NUM_POOLS * MAX_BLOCKS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CMPW  = (CW > INDEX_W) ? CW : INDEX_W;
  localparam logic [SUM_W-1:0]   HDR_S = SUM_W'(HEADER_BYTES);
  localparam logic [BYTES_W-1:0] HDR_B = BYTES_W'(HEADER_BYTES);

  // entry: {free, size}
  logic [BYTES_W:0] mem [DEPTH];
  logic [BYTES_W:0] rd_data_r;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [BYTES_W:0] wr_data;

  logic [BYTES_W-1:0] pool_bytes_r [NUM_POOLS];
  logic [CW-1:0]      count_r      [NUM_POOLS];
  logic [BYTES_W-1:0] occ_r        [NUM_POOLS];
  logic               fresh_r      [NUM_POOLS];

  state_t             state_r, state_nxt;
  logic [PW-1:0]      pool_r, pool_nxt;
  logic [AW-1:0]      base_r, base_nxt;
  logic [BYTES_W-1:0] req_bytes_r, req_bytes_nxt;
  logic [BYTES_W-1:0] stub_r, stub_nxt;
  logic [IW-1:0]      idx_r, idx_nxt;
  logic [BYTES_W-1:0] off_r, off_nxt;
  ffpa_out_t          res_r, res_nxt;
  logic               grow;

  logic               pool_ok;
  logic [PW-1:0]      in_pool;
  logic [AW-1:0]      base_in;
  logic               free_ok;
  logic               exhausted;

  logic [CW-1:0]      cnt;
  logic [BYTES_W-1:0] pbytes;
  logic [BYTES_W-1:0] init_size;
  logic               ent_free;
  logic [BYTES_W-1:0] ent_size;
  logic [SUM_W-1:0]   need;
  logic               fit;
  logic               tail;
  logic               full;

  logic               cfg_hit;
  logic [PW-1:0]      cfg_pool;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign pool_ok = ({31'd0, req.pool_select} < 32'(NUM_POOLS));
  assign in_pool = pool_ok ? PW'(req.pool_select) : '0;
  assign base_in = AW'(AW'(in_pool) * AW'(MAX_BLOCKS));
  assign free_ok = pool_ok && (CMPW'(req.free_index) < CMPW'(count_r[in_pool]));
  assign exhausted = !pool_ok ||
                     (SUM_W'(pool_bytes_r[in_pool]) <=
                      SUM_W'(occ_r[in_pool]) + SUM_W'(req.request_bytes) + HDR_S);

  assign cnt       = count_r[pool_r];
  assign pbytes    = pool_bytes_r[pool_r];
  assign init_size = (pbytes > HDR_B) ? (pbytes - HDR_B) : '0;
  assign ent_free  = (fresh_r[pool_r] && (idx_r == '0)) ? 1'b1 : rd_data_r[BYTES_W];
  assign ent_size  = (fresh_r[pool_r] && (idx_r == '0)) ? init_size
                                                       : rd_data_r[BYTES_W-1:0];
  assign need      = SUM_W'(req_bytes_r) + HDR_S;
  assign fit       = ent_free && (SUM_W'(ent_size) > need);
  assign tail      = ((CW'(idx_r) + CW'(1)) == cnt);
  assign full      = (cnt == CW'(MAX_BLOCKS));

  assign cfg_hit  = cfg.en && (cfg.idx <= REG_POOL1) &&
                    ({30'd0, cfg.idx} < 32'(NUM_POOLS));
  assign cfg_pool = PW'(cfg.idx);

  always_comb begin
    state_nxt     = state_r;
    pool_nxt      = pool_r;
    base_nxt      = base_r;
    req_bytes_nxt = req_bytes_r;
    stub_nxt      = stub_r;
    idx_nxt       = idx_r;
    off_nxt       = off_r;
    res_nxt       = res_r;
    rd_addr       = base_r + AW'(idx_r);
    wr_en         = 1'b0;
    wr_addr       = base_r + AW'(idx_r);
    wr_data       = '0;
    grow          = 1'b0;
    req_ready     = 1'b0;
    res_valid     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          pool_nxt      = in_pool;
          base_nxt      = base_in;
          req_bytes_nxt = req.request_bytes;
          off_nxt       = '0;
          if (req.action == ACT_FREE) begin
            if (free_ok) begin
              idx_nxt   = IW'(req.free_index);
              rd_addr   = base_in + AW'(IW'(req.free_index));
              state_nxt = ST_FREE_RD;
            end else begin
              res_nxt   = '{STAT_BAD_INDEX, '0, '0, '0};
              state_nxt = ST_DONE;
            end
          end else begin
            if (exhausted) begin
              res_nxt   = '{STAT_EXHAUSTED, '0, '0, '0};
              state_nxt = ST_DONE;
            end else begin
              idx_nxt   = '0;
              rd_addr   = base_in;
              state_nxt = ST_WALK;
            end
          end
        end
      end
      ST_FREE_RD: begin
        wr_en     = 1'b1;
        wr_data   = {1'b1, ent_size};
        res_nxt   = '{STAT_OK, INDEX_W'(idx_r), '0, ent_size};
        state_nxt = ST_DONE;
      end
      ST_WALK: begin
        if (fit) begin
          if (tail) begin
            if (full) begin
              res_nxt   = '{STAT_FULL, '0, '0, '0};
              state_nxt = ST_DONE;
            end else begin
              wr_en     = 1'b1;
              wr_data   = {1'b0, req_bytes_r};
              stub_nxt  = BYTES_W'(SUM_W'(ent_size) - need);
              res_nxt   = '{STAT_OK, INDEX_W'(idx_r), off_r, req_bytes_r};
              state_nxt = ST_STUB;
            end
          end else begin
            wr_en     = 1'b1;
            wr_data   = {1'b0, ent_size};
            res_nxt   = '{STAT_OK, INDEX_W'(idx_r), off_r, ent_size};
            state_nxt = ST_DONE;
          end
        end else if (tail) begin
          res_nxt   = '{STAT_NO_FIT, '0, '0, '0};
          state_nxt = ST_DONE;
        end else begin
          idx_nxt = idx_r + IW'(1);
          off_nxt = off_r + HDR_B + ent_size;
          rd_addr = base_r + AW'(idx_r + IW'(1));
        end
      end
      ST_STUB: begin
        wr_en     = 1'b1;
        wr_addr   = base_r + AW'(cnt[IW-1:0]);
        wr_data   = {1'b1, stub_r};
        grow      = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      for (int p = 0; p < NUM_POOLS; p++) begin
        pool_bytes_r[p] <= POOL_BYTES_RST;
        count_r[p]      <= CW'(1);
        occ_r[p]        <= HDR_B;
        fresh_r[p]      <= 1'b1;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_hit) begin
        pool_bytes_r[cfg_pool] <= cfg.value;
        count_r[cfg_pool]      <= CW'(1);
        occ_r[cfg_pool]        <= HDR_B;
        fresh_r[cfg_pool]      <= 1'b1;
      end else begin
        if (wr_en && (state_r != ST_STUB) && (idx_r == '0)) begin
          fresh_r[pool_r] <= 1'b0;
        end
        if (grow) begin
          count_r[pool_r] <= cnt + CW'(1);
          occ_r[pool_r]   <= BYTES_W'(SUM_W'(occ_r[pool_r]) + need);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pool_r      <= pool_nxt;
    base_r      <= base_nxt;
    req_bytes_r <= req_bytes_nxt;
    stub_r      <= stub_nxt;
    idx_r       <= idx_nxt;
    off_r       <= off_nxt;
    res_r       <= res_nxt;
  end

  assign res = res_r;

endmodule

### hdl/first_fit_pool_allocator.sv
`timescale 1ns / 1ps

// channel   handshake               beat
// in        in_valid / in_ready     ffpa_in_t  in_data
// out       out_valid / out_ready   ffpa_out_t out_data
// cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A free reads, then frees its entry; an error found at accept goes straight to the result.
// An allocate walks from block 0 until it stops at block k, plus a tail write when it splits:
// the walk reads one table entry per cycle from the block table (one read port, one write port).
// Reset makes each pool one free block of 65536 minus a header; no clearing pass is needed.
// A result waits in the output register; the engine holds its next result until that drains.

module first_fit_pool_allocator
  import ffpa_pkg::*;
#(
  parameter int MAX_BLOCKS   = 256,
  parameter int HEADER_BYTES = 16,
  parameter int NUM_POOLS    = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ffpa_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ffpa_out_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTES_W-1:0]   cfg_data
);

  cfg_wr_t   cfg;
  logic      res_valid;
  logic      res_take;
  ffpa_out_t res;
  logic      out_valid_r;
  ffpa_out_t out_data_r;

  assign cfg       = '{en: cfg_valid, idx: cfg_index, value: cfg_data};
  assign cfg_ready = 1'b1;

  ffpa_core #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES),
    .NUM_POOLS    (NUM_POOLS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req_ready (in_ready),
    .req       (in_data),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // load the output register when it is empty or draining
  assign res_take = res_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ffpa_pkg::*;

  localparam int MAX_BLK     = 256;
  localparam int HDR         = 16;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 200;
  localparam int TAIL_WAIT   = 300;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE3 = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  ffpa_in_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  ffpa_out_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTES_W-1:0]   cfg_data;

  longint unsigned    pool_sz [2];
  longint unsigned    used_bytes [2];
  int unsigned        blk_cnt [2];
  logic [BYTES_W-1:0] blk_size [2][MAX_BLK];
  bit                 blk_free [2][MAX_BLK];

  ffpa_out_t grant_q[$];
  int        errors;
  int        checked;
  int        sent_count;
  int        cfg_writes;
  int        status_seen [8];
  bit        calm;
  int        hold_asks;

  first_fit_pool_allocator #(
    .MAX_BLOCKS  (MAX_BLK),
    .HEADER_BYTES(HDR),
    .NUM_POOLS   (2)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #25_000_000;
    $display("FAIL first_fit_pool_allocator");
    $finish;
  end

  function automatic void reset_pool(int p);
    for (int k = 0; k < MAX_BLK; k++) begin
      blk_size[p][k] = '0;
      blk_free[p][k] = 1'b0;
    end
    blk_size[p][0] = (pool_sz[p] > HDR) ? BYTES_W'(pool_sz[p] - HDR) : '0;
    blk_free[p][0] = 1'b1;
    blk_cnt[p]     = 1;
    used_bytes[p]  = 64'(HDR);
  endfunction

  function automatic ffpa_out_t predict_grant(ffpa_in_t rq);
    ffpa_out_t       r;
    int              p;
    int unsigned     k;
    int unsigned     cnt;
    longint unsigned need;
    longint unsigned off;
    longint unsigned rest;
    bit              hit;
    r = '0;
    p = int'(rq.pool_select);
    if (rq.action == ACT_FREE) begin
      if (rq.free_index >= blk_cnt[p]) begin
        r.status = STAT_BAD_INDEX;
        return r;
      end
      blk_free[p][rq.free_index] = 1'b1;
      r.status      = STAT_OK;
      r.block_index = rq.free_index;
      r.block_bytes = blk_size[p][rq.free_index];
      return r;
    end
    need = longint'(rq.request_bytes) + HDR;
    if (pool_sz[p] <= used_bytes[p] + need) begin
      r.status = STAT_EXHAUSTED;
      return r;
    end
    cnt = blk_cnt[p];
    off = 0;
    hit = 1'b0;
    for (k = 0; k < cnt; k++) begin
      if (blk_size[p][k] > need && blk_free[p][k]) begin
        hit = 1'b1;
        break;
      end
      off += HDR + longint'(blk_size[p][k]);
    end
    if (!hit) begin
      r.status = STAT_NO_FIT;
      return r;
    end
    if (k == cnt - 1) begin
      if (cnt >= MAX_BLK) begin
        r.status = STAT_FULL;
        return r;
      end
      rest               = longint'(blk_size[p][k]) - need;
      used_bytes[p]      = (used_bytes[p] + need) & 64'hFF_FFFF;
      blk_size[p][cnt]   = BYTES_W'(rest);
      blk_free[p][cnt]   = 1'b1;
      blk_size[p][k]     = rq.request_bytes;
      blk_cnt[p]         = cnt + 1;
    end
    blk_free[p][k] = 1'b0;
    r.status       = STAT_OK;
    r.block_index  = INDEX_W'(k);
    r.block_offset = BYTES_W'(off);
    r.block_bytes  = blk_size[p][k];
    return r;
  endfunction

  function automatic logic [BYTES_W-1:0] tail_room(int p);
    if (pool_sz[p] > used_bytes[p] + HDR + 1) begin
      return BYTES_W'(pool_sz[p] - used_bytes[p] - HDR - 1);
    end
    return '0;
  endfunction

  function automatic ffpa_in_t req_item(logic act, logic p, logic [BYTES_W-1:0] nbytes,
                                        logic [INDEX_W-1:0] idx);
    ffpa_in_t it;
    it.action        = act;
    it.pool_select   = p;
    it.request_bytes = nbytes;
    it.free_index    = idx;
    return it;
  endfunction

  task automatic send_req(input ffpa_in_t rq);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  = rq;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    grant_q.push_back(predict_grant(rq));
    sent_count++;
    @(negedge clk);
  endtask

  task automatic settle_idle();
    in_valid = 1'b0;
    while (grant_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTES_W-1:0] val);
    settle_idle();
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_POOL0 || idx == REG_POOL1) begin
      pool_sz[idx] = 64'(val);
      reset_pool(int'(idx));
    end
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin : receiver
    int stall_left;
    int hold_left;
    int hold_seen;
    bit rdy;
    stall_left = 0;
    hold_left  = 0;
    hold_seen  = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_ready = rdy;
    end
  end

  always @(posedge clk) begin : result_check
    ffpa_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (grant_q.size() == 0) begin
        $error("result beat with nothing pending: status %0d index %0d",
               out_data.status, out_data.block_index);
        errors++;
      end else begin
        want = grant_q.pop_front();
        checked++;
        status_seen[want.status]++;
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          errors++;
        end
        if (out_data.block_index !== want.block_index) begin
          $error("block_index: expected %0d, got %0d", want.block_index, out_data.block_index);
          errors++;
        end
        if (out_data.block_offset !== want.block_offset) begin
          $error("block_offset: expected %0d, got %0d", want.block_offset,
                 out_data.block_offset);
          errors++;
        end
        if (out_data.block_bytes !== want.block_bytes) begin
          $error("block_bytes: expected %0d, got %0d", want.block_bytes, out_data.block_bytes);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_req(req_item(ACT_ALLOC, 1'b0, 24'd0, 8'hFF));
    send_req(req_item(ACT_ALLOC, 1'b0, 24'd100, 8'hAA));
    send_req(req_item(ACT_ALLOC, 1'b1, 24'hFF_FFFF, 8'h00));
    send_req(req_item(ACT_FREE, 1'b0, 24'hFF_FFFF, 8'd0));
    send_req(req_item(ACT_FREE, 1'b0, 24'd0, 8'd0));
    send_req(req_item(ACT_FREE, 1'b0, 24'd0, 8'hFF));
    send_req(req_item(ACT_FREE, 1'b1, 24'd0, 8'd1));
    send_req(req_item(ACT_FREE, 1'b0, 24'h55_AA55, 8'd1));
    send_req(req_item(ACT_ALLOC, 1'b0, 24'd50, 8'd0));
    send_req(req_item(ACT_ALLOC, 1'b0, 24'd0, 8'd0));
    send_req(req_item(ACT_ALLOC, 1'b1, tail_room(1), 8'd0));
    send_req(req_item(ACT_ALLOC, 1'b1, 24'd0, 8'd0));
    send_req(req_item(ACT_FREE, 1'b1, 24'd0, 8'd1));

    write_reg(REG_POOL0, 24'd64);
    write_reg(REG_POOL1, 24'hFF_FFFF);
    write_reg(REG_SPARE2, 24'hFF_FFFF);
    write_reg(REG_SPARE3, 24'd0);
    send_req(req_item(ACT_ALLOC, 1'b0, tail_room(0), 8'd0));
    send_req(req_item(ACT_ALLOC, 1'b0, 24'd0, 8'd0));
    send_req(req_item(ACT_ALLOC, 1'b1, tail_room(1), 8'd0));
    send_req(req_item(ACT_ALLOC, 1'b1, 24'hFF_FFFF, 8'd0));

    write_reg(REG_POOL0, 24'd0);
    write_reg(REG_POOL1, 24'd17);
    send_req(req_item(ACT_ALLOC, 1'b0, 24'd0, 8'd0));
    send_req(req_item(ACT_FREE, 1'b0, 24'd0, 8'd0));
    send_req(req_item(ACT_FREE, 1'b1, 24'd0, 8'd0));
    send_req(req_item(ACT_ALLOC, 1'b1, 24'd0, 8'd0));
  endtask

  task automatic test_table_full();
    write_reg(REG_POOL0, 24'd65536);
    write_reg(REG_POOL1, 24'd20000);
    while (blk_cnt[0] < MAX_BLK) begin
      if ($urandom_range(0, 7) == 0) begin
        send_req(req_item($urandom_range(0, 1) ? ACT_FREE : ACT_ALLOC, 1'b1,
                          BYTES_W'($urandom_range(0, 40)),
                          INDEX_W'($urandom_range(0, blk_cnt[1] - 1))));
      end else begin
        send_req(req_item(ACT_ALLOC, 1'b0, BYTES_W'($urandom_range(0, 40)),
                          INDEX_W'($urandom)));
      end
    end
    send_req(req_item(ACT_ALLOC, 1'b0, 24'd0, 8'd0));
    send_req(req_item(ACT_FREE, 1'b0, 24'd0, 8'd255));
    send_req(req_item(ACT_ALLOC, 1'b0, 24'd0, 8'd0));
    repeat (6) send_req(req_item(ACT_FREE, 1'b0, 24'd0, INDEX_W'($urandom_range(0, 254))));
    repeat (6) send_req(req_item(ACT_ALLOC, 1'b0, BYTES_W'($urandom_range(0, 24)), 8'd0));
  endtask

  task automatic test_backpressure();
    calm = 1'b1;
    hold_asks++;
    for (int n = 0; n < 12; n++) begin
      if (n % 2 == 0) begin
        send_req(req_item(ACT_FREE, 1'b0, 24'd0, INDEX_W'($urandom_range(0, blk_cnt[0] - 1))));
      end else begin
        send_req(req_item(ACT_ALLOC, 1'b0, BYTES_W'($urandom_range(0, 24)), 8'd0));
      end
    end
    calm = 1'b0;
  endtask

  task automatic test_random();
    int                 favored;
    int                 p;
    int                 k;
    int unsigned        cap;
    logic [BYTES_W-1:0] sz;
    logic [BYTES_W-1:0] pick;
    ffpa_in_t           rq;
    for (int ph = 0; ph < PHASES; ph++) begin
      for (int r = 0; r < 2; r++) begin
        case ($urandom_range(0, 5))
          0:       pick = 24'd64;
          1:       pick = 24'hFF_FFFF;
          2:       pick = 24'd65536;
          3:       pick = BYTES_W'($urandom_range(64, 8192));
          4:       pick = BYTES_W'($urandom);
          default: pick = BYTES_W'($urandom_range(0, 40));
        endcase
        write_reg(r == 0 ? REG_POOL0 : REG_POOL1, pick);
      end
      if ($urandom_range(0, 2) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE2 : REG_SPARE3, BYTES_W'($urandom));
      end
      if (ph == PHASES - 1) calm = 1'b1;
      favored = $urandom_range(0, 1);
      repeat (PHASE_ITEMS) begin
        p = ($urandom_range(0, 3) == 0) ? 1 - favored : favored;
        rq.pool_select   = p[0];
        rq.request_bytes = BYTES_W'($urandom);
        rq.free_index    = INDEX_W'($urandom);
        if ($urandom_range(0, 9) < 6) begin
          rq.action = ACT_ALLOC;
          cap = int'(pool_sz[p] / 300);
          if (cap < 4) cap = 4;
          case ($urandom_range(0, 9))
            0: rq.request_bytes = '1;
            1: ;
            2: rq.request_bytes = tail_room(p) + BYTES_W'($urandom_range(0, 1));
            3: begin
              k  = $urandom_range(0, blk_cnt[p] - 1);
              sz = blk_size[p][k];
              rq.request_bytes = (sz >= 17) ?
                                 sz - BYTES_W'(16) - BYTES_W'($urandom_range(0, 1)) : '0;
            end
            default: rq.request_bytes = BYTES_W'($urandom_range(0, cap));
          endcase
        end else begin
          rq.action = ACT_FREE;
          if ($urandom_range(0, 7) != 0) begin
            rq.free_index = INDEX_W'($urandom_range(0, blk_cnt[p] - 1));
          end
        end
        send_req(rq);
      end
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    calm       = 1'b0;
    hold_asks  = 0;
    errors     = 0;
    checked    = 0;
    sent_count = 0;
    cfg_writes = 0;
    for (int s = 0; s < 8; s++) status_seen[s] = 0;
    for (int p = 0; p < 2; p++) begin
      pool_sz[p] = 64'(POOL_BYTES_RST);
      reset_pool(p);
    end
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_table_full();
    test_backpressure();
    test_random();

    settle_idle();
    repeat (TAIL_WAIT) @(negedge clk);
    $display("Covered %0d requests and %0d register writes: %0d ok, %0d exhausted,",
             sent_count, checked == 0 ? 0 : cfg_writes, status_seen[STAT_OK],
             status_seen[STAT_EXHAUSTED]);
    $display("  %0d table full, %0d bad index; %0d results checked, %0d mismatches",
             status_seen[STAT_FULL], status_seen[STAT_BAD_INDEX], checked, errors);
    if (errors == 0 && grant_q.size() == 0) begin
      $display("PASS first_fit_pool_allocator");
    end else begin
      $display("FAIL first_fit_pool_allocator");
    end
    $finish;
  end

endmodule
